>>> design/qcfm_pkg.sv
// ----------------------------------------------------------------------------
// qcfm_pkg
// shared widths, face codes and the tag that travels with each face beat
// ----------------------------------------------------------------------------
package qcfm_pkg;

    localparam int CoordW = 32;               // Q16.16 corner coordinate
    localparam int DiffW  = CoordW + 1;       // signed coordinate difference
    localparam int MagW   = 32;               // magnitude of a difference
    localparam int ProdW  = 2 * MagW;         // square or diagonal product
    localparam int SumW   = ProdW + 1;        // sum of squares, cross product
    localparam int RadW   = 94;               // sum of squares times 2^28, even
    localparam int RootW  = RadW / 2;         // Q17.30 length
    localparam int RemW   = RootW + 4;        // square root partial remainder
    localparam int AreaW  = 63;
    localparam int LenW   = 32;
    localparam int NormW  = 16;
    localparam int QuoW   = 15;               // normal magnitude never exceeds 2^14
    localparam int DivW   = MagW + 29;        // rounded dividend

    localparam logic [AreaW-1:0] AREA_MAX = {AreaW{1'b1}};
    localparam logic [LenW-1:0]  LEN_MAX  = {LenW{1'b1}};

    typedef enum logic [1:0] {
        SIDE_EAST  = 2'd0,
        SIDE_WEST  = 2'd1,
        SIDE_NORTH = 2'd2,
        SIDE_SOUTH = 2'd3
    } t_side;

    typedef struct packed {
        t_side             side;
        logic              last;
        logic              zero;
        logic [AreaW-1:0]  area;
        logic              nx_neg;
        logic              ny_neg;
        logic [MagW-1:0]   nx_mag;
        logic [MagW-1:0]   ny_mag;
    } t_tag;

endpackage

>>> design/qcfm_cell_if.sv
// ----------------------------------------------------------------------------
// qcfm_cell_if
// cell channel: four corner points of one quadrilateral cell
// ----------------------------------------------------------------------------
interface qcfm_cell_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] bottom_left_x;
    logic signed [31:0] bottom_left_y;
    logic signed [31:0] bottom_right_x;
    logic signed [31:0] bottom_right_y;
    logic signed [31:0] top_left_x;
    logic signed [31:0] top_left_y;
    logic signed [31:0] top_right_x;
    logic signed [31:0] top_right_y;

    modport source (
        output valid, bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y,
               top_left_x, top_left_y, top_right_x, top_right_y,
        input  ready
    );
    modport sink (
        input  valid, bottom_left_x, bottom_left_y, bottom_right_x, bottom_right_y,
               top_left_x, top_left_y, top_right_x, top_right_y,
        output ready
    );
endinterface

>>> design/qcfm_face_if.sv
// ----------------------------------------------------------------------------
// qcfm_face_if
// face channel: length, unit normal and cell area of one face
// ----------------------------------------------------------------------------
interface qcfm_face_if;
    logic               valid;
    logic               ready;
    logic [1:0]         face_side;
    logic [31:0]        face_length;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [62:0]        cell_area;
    logic               zero_face;
    logic               last_face;

    modport source (
        output valid, face_side, face_length, normal_x, normal_y, cell_area,
               zero_face, last_face,
        input  ready
    );
    modport sink (
        input  valid, face_side, face_length, normal_x, normal_y, cell_area,
               zero_face, last_face,
        output ready
    );
endinterface

>>> design/qcfm_front.sv
// ----------------------------------------------------------------------------
// qcfm_front
// face sequencer, differences, squares and diagonal products, area
// ----------------------------------------------------------------------------
module qcfm_front
    import qcfm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    qcfm_cell_if.sink       i_cell,
    output logic            o_valid,
    output t_tag            o_tag,
    output logic [RadW-1:0] o_rad
);

    // sequencer
    logic                     r_busy;
    t_side                    r_phase;
    logic signed [CoordW-1:0] r_blx, r_bly, r_brx, r_bry, r_tlx, r_tly, r_trx, r_try;
    logic                     n_load;

    // stage a
    logic                   r_a_vld;
    t_side                  r_a_side;
    logic                   r_a_last;
    logic signed [DiffW-1:0] r_a_nx, r_a_ny, r_a_dx1, r_a_dy1, r_a_dx2, r_a_dy2;

    // stage b
    logic             r_b_vld;
    t_side            r_b_side;
    logic             r_b_last;
    logic             r_b_nx_neg, r_b_ny_neg, r_b_pneg, r_b_qneg;
    logic [MagW-1:0]  r_b_nx_mag, r_b_ny_mag;
    logic [ProdW-1:0] r_b_sqx, r_b_sqy, r_b_p, r_b_q;

    // stage c
    logic            r_c_vld;
    t_tag            r_c_tag;
    logic [RadW-1:0] r_c_rad;

    logic signed [CoordW-1:0] w_px, w_py, w_qx, w_qy;
    logic [MagW-1:0]  w_nx_mag, w_ny_mag, w_dx1_mag, w_dy1_mag, w_dx2_mag, w_dy2_mag;
    logic [SumW-1:0]  w_s, w_cr;
    logic [AreaW-1:0] w_area;

    function automatic logic [MagW-1:0] f_mag(input logic signed [DiffW-1:0] d);
        logic signed [DiffW-1:0] a;
        a = d[DiffW-1] ? -d : d;
        return a[MagW-1:0];
    endfunction

    assign i_cell.ready = !r_busy || (i_adv && r_phase == SIDE_SOUTH);
    assign n_load       = i_cell.valid && i_cell.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= SIDE_EAST;
        end else begin
            if (n_load) begin
                r_busy  <= 1'b1;
                r_phase <= SIDE_EAST;
                r_blx   <= i_cell.bottom_left_x;
                r_bly   <= i_cell.bottom_left_y;
                r_brx   <= i_cell.bottom_right_x;
                r_bry   <= i_cell.bottom_right_y;
                r_tlx   <= i_cell.top_left_x;
                r_tly   <= i_cell.top_left_y;
                r_trx   <= i_cell.top_right_x;
                r_try   <= i_cell.top_right_y;
            end else if (i_adv && r_busy) begin
                if (r_phase == SIDE_SOUTH) begin
                    r_busy <= 1'b0;
                end else begin
                    r_phase <= t_side'(r_phase + 2'd1);
                end
            end
        end
    end

    // face from p to q
    always_comb begin
        unique case (r_phase)
            SIDE_EAST: begin
                w_px = r_trx; w_py = r_try; w_qx = r_brx; w_qy = r_bry;
            end
            SIDE_WEST: begin
                w_px = r_blx; w_py = r_bly; w_qx = r_tlx; w_qy = r_tly;
            end
            SIDE_NORTH: begin
                w_px = r_tlx; w_py = r_tly; w_qx = r_trx; w_qy = r_try;
            end
            SIDE_SOUTH: begin
                w_px = r_brx; w_py = r_bry; w_qx = r_blx; w_qy = r_bly;
            end
            default: begin
                w_px = r_trx; w_py = r_try; w_qx = r_brx; w_qy = r_bry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_adv) begin
            r_a_vld  <= r_busy;
            r_a_side <= r_phase;
            r_a_last <= (r_phase == SIDE_SOUTH);
            r_a_nx   <= DiffW'(w_py) - DiffW'(w_qy);
            r_a_ny   <= DiffW'(w_qx) - DiffW'(w_px);
            r_a_dx1  <= DiffW'(r_trx) - DiffW'(r_blx);
            r_a_dy1  <= DiffW'(r_try) - DiffW'(r_bly);
            r_a_dx2  <= DiffW'(r_tlx) - DiffW'(r_brx);
            r_a_dy2  <= DiffW'(r_tly) - DiffW'(r_bry);
        end
    end

    assign w_nx_mag  = f_mag(r_a_nx);
    assign w_ny_mag  = f_mag(r_a_ny);
    assign w_dx1_mag = f_mag(r_a_dx1);
    assign w_dy1_mag = f_mag(r_a_dy1);
    assign w_dx2_mag = f_mag(r_a_dx2);
    assign w_dy2_mag = f_mag(r_a_dy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_adv) begin
            r_b_vld    <= r_a_vld;
            r_b_side   <= r_a_side;
            r_b_last   <= r_a_last;
            r_b_nx_neg <= r_a_nx[DiffW-1];
            r_b_ny_neg <= r_a_ny[DiffW-1];
            r_b_nx_mag <= w_nx_mag;
            r_b_ny_mag <= w_ny_mag;
            r_b_pneg   <= r_a_dx1[DiffW-1] != r_a_dy2[DiffW-1];
            r_b_qneg   <= r_a_dx2[DiffW-1] != r_a_dy1[DiffW-1];
            r_b_sqx    <= w_nx_mag * w_nx_mag;
            r_b_sqy    <= w_ny_mag * w_ny_mag;
            r_b_p      <= w_dx1_mag * w_dy2_mag;
            r_b_q      <= w_dx2_mag * w_dy1_mag;
        end
    end

    assign w_s = SumW'(r_b_sqx) + SumW'(r_b_sqy);

    // absolute cross product of the diagonals
    always_comb begin
        priority if (r_b_pneg != r_b_qneg) begin
            w_cr = SumW'(r_b_p) + SumW'(r_b_q);
        end else if (r_b_q <= r_b_p) begin
            w_cr = SumW'(r_b_p - r_b_q);
        end else begin
            w_cr = SumW'(r_b_q - r_b_p);
        end
    end

    assign w_area = w_cr[SumW-1] ? AREA_MAX : w_cr[AreaW:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_adv) begin
            r_c_vld        <= r_b_vld;
            r_c_tag.side   <= r_b_side;
            r_c_tag.last   <= r_b_last;
            r_c_tag.zero   <= (r_b_nx_mag == '0) && (r_b_ny_mag == '0);
            r_c_tag.area   <= w_area;
            r_c_tag.nx_neg <= r_b_nx_neg;
            r_c_tag.ny_neg <= r_b_ny_neg;
            r_c_tag.nx_mag <= r_b_nx_mag;
            r_c_tag.ny_mag <= r_b_ny_mag;
            r_c_rad        <= RadW'({w_s, 28'b0});
        end
    end

    assign o_valid = r_c_vld;
    assign o_tag   = r_c_tag;
    assign o_rad   = r_c_rad;

endmodule

>>> design/qcfm_sqrt.sv
// ----------------------------------------------------------------------------
// qcfm_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module qcfm_sqrt
    import qcfm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  t_tag             i_tag,
    input  logic [RadW-1:0]  i_rad,
    output logic             o_valid,
    output t_tag             o_tag,
    output logic [RootW-1:0] o_root
);

    logic [RootW-1:0] r_vld;
    t_tag             r_tag  [RootW];
    logic [RemW-1:0]  r_rem  [RootW];
    logic [RootW-1:0] r_root [RootW];
    logic [RadW-1:0]  r_rad  [RootW];

    logic [RemW-1:0]  w_prem  [RootW];
    logic [RootW-1:0] w_proot [RootW];
    logic [RadW-1:0]  w_prad  [RootW];
    logic [RemW-1:0]  w_cur   [RootW];
    logic [RemW-1:0]  w_trial [RootW];
    logic [RemW-1:0]  n_rem   [RootW];
    logic [RootW-1:0] n_root  [RootW];

    always_comb begin
        for (int k = 0; k < RootW; k++) begin
            w_prem[k]  = (k == 0) ? '0    : r_rem[(k == 0) ? 0 : k - 1];
            w_proot[k] = (k == 0) ? '0    : r_root[(k == 0) ? 0 : k - 1];
            w_prad[k]  = (k == 0) ? i_rad : r_rad[(k == 0) ? 0 : k - 1];
            // bring down the next two radicand bits
            w_cur[k]   = {w_prem[k][RemW-3:0], w_prad[k][RadW-1:RadW-2]};
            w_trial[k] = RemW'({w_proot[k], 2'b01});
            if (w_cur[k] >= w_trial[k]) begin
                n_rem[k]  = w_cur[k] - w_trial[k];
                n_root[k] = {w_proot[k][RootW-2:0], 1'b1};
            end else begin
                n_rem[k]  = w_cur[k];
                n_root[k] = {w_proot[k][RootW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[RootW-2:0], i_valid};
            for (int k = 0; k < RootW; k++) begin
                r_tag[k]  <= (k == 0) ? i_tag : r_tag[(k == 0) ? 0 : k - 1];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= {w_prad[k][RadW-3:0], 2'b00};
            end
        end
    end

    assign o_valid = r_vld[RootW-1];
    assign o_tag   = r_tag[RootW-1];
    assign o_root  = r_root[RootW-1];

endmodule

>>> design/qcfm_div.sv
// ----------------------------------------------------------------------------
// qcfm_div
// face length and two pipelined restoring dividers for the unit normal
// ----------------------------------------------------------------------------
module qcfm_div
    import qcfm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  t_tag             i_tag,
    input  logic [RootW-1:0] i_root,
    output logic             o_valid,
    output t_tag             o_tag,
    output logic [LenW-1:0]  o_len,
    output logic [QuoW-1:0]  o_qx,
    output logic [QuoW-1:0]  o_qy
);

    logic [QuoW-1:0]  r_vld;
    t_tag             r_tag  [QuoW];
    logic [RootW-1:0] r_root [QuoW];
    logic [LenW-1:0]  r_len  [QuoW];
    logic [DivW-1:0]  r_rx   [QuoW];
    logic [DivW-1:0]  r_ry   [QuoW];
    logic [QuoW-1:0]  r_qx   [QuoW];
    logic [QuoW-1:0]  r_qy   [QuoW];

    logic [LenW-1:0]  w_len;
    logic [DivW-1:0]  w_rx0, w_ry0;
    logic [RootW-1:0] w_proot [QuoW];
    logic [DivW-1:0]  w_prx   [QuoW];
    logic [DivW-1:0]  w_pry   [QuoW];
    logic [QuoW-1:0]  w_pqx   [QuoW];
    logic [QuoW-1:0]  w_pqy   [QuoW];
    logic [DivW-1:0]  w_dv    [QuoW];
    logic [DivW-1:0]  n_rx    [QuoW];
    logic [DivW-1:0]  n_ry    [QuoW];
    logic [QuoW-1:0]  n_qx    [QuoW];
    logic [QuoW-1:0]  n_qy    [QuoW];

    // length is the Q17.30 root cut to Q16.16
    assign w_len = i_root[RootW-1] ? LEN_MAX : i_root[RootW-2:RootW-1-LenW];

    // rounded dividend: mag * 2^28 + root / 2
    assign w_rx0 = DivW'({i_tag.nx_mag, 28'b0}) + DivW'(i_root >> 1);
    assign w_ry0 = DivW'({i_tag.ny_mag, 28'b0}) + DivW'(i_root >> 1);

    always_comb begin
        for (int k = 0; k < QuoW; k++) begin
            w_proot[k] = (k == 0) ? i_root : r_root[(k == 0) ? 0 : k - 1];
            w_prx[k]   = (k == 0) ? w_rx0  : r_rx[(k == 0) ? 0 : k - 1];
            w_pry[k]   = (k == 0) ? w_ry0  : r_ry[(k == 0) ? 0 : k - 1];
            w_pqx[k]   = (k == 0) ? '0     : r_qx[(k == 0) ? 0 : k - 1];
            w_pqy[k]   = (k == 0) ? '0     : r_qy[(k == 0) ? 0 : k - 1];
            w_dv[k]    = DivW'(w_proot[k]) << (QuoW - 1 - k);
            n_qx[k]    = w_pqx[k];
            n_qy[k]    = w_pqy[k];
            if (w_prx[k] >= w_dv[k]) begin
                n_rx[k]                 = w_prx[k] - w_dv[k];
                n_qx[k][QuoW - 1 - k]   = 1'b1;
            end else begin
                n_rx[k] = w_prx[k];
            end
            if (w_pry[k] >= w_dv[k]) begin
                n_ry[k]                 = w_pry[k] - w_dv[k];
                n_qy[k][QuoW - 1 - k]   = 1'b1;
            end else begin
                n_ry[k] = w_pry[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[QuoW-2:0], i_valid};
            for (int k = 0; k < QuoW; k++) begin
                r_tag[k]  <= (k == 0) ? i_tag : r_tag[(k == 0) ? 0 : k - 1];
                r_len[k]  <= (k == 0) ? w_len : r_len[(k == 0) ? 0 : k - 1];
                r_root[k] <= w_proot[k];
                r_rx[k]   <= n_rx[k];
                r_ry[k]   <= n_ry[k];
                r_qx[k]   <= n_qx[k];
                r_qy[k]   <= n_qy[k];
            end
        end
    end

    assign o_valid = r_vld[QuoW-1];
    assign o_tag   = r_tag[QuoW-1];
    assign o_len   = r_len[QuoW-1];
    assign o_qx    = r_qx[QuoW-1];
    assign o_qy    = r_qy[QuoW-1];

endmodule

>>> design/quad_cell_face_metrics.sv
// ----------------------------------------------------------------------------
// quad_cell_face_metrics
// face length, outward unit normal and area of one quadrilateral mesh cell
// ----------------------------------------------------------------------------
// i_cell takes one cell beat: four corners in signed Q16.16. o_face gives four
// beats per cell in the order east, west, north, south; the south beat has
// last_face set, and every beat carries the same cell area.
// While the receiver does not stall, a new face enters the pipeline every
// cycle, so a cell is taken once its four faces have entered and the face
// channel can stay busy on every cycle. Cells may follow each other without
// gaps; the next cell is taken in the cycle the current one issues its south
// face. The path to the face output runs through the corner registers, three
// stages of differences, products and area, 47 square root stages (one root
// bit each), 15 divider stages (one normal bit each) and the output register.
// A zero-length face gives zero length and normal with zero_face set. When
// the receiver holds ready low with a face waiting at the output, the whole
// pipeline freezes in place, nothing is lost or repeated, and i_cell.ready
// stays low while a cell still has faces to send. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module quad_cell_face_metrics
    import qcfm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    qcfm_cell_if.sink    i_cell,
    qcfm_face_if.source  o_face
);

    logic             w_adv;
    logic             w_f_vld, w_s_vld, w_d_vld;
    t_tag             w_f_tag, w_s_tag, w_d_tag;
    logic [RadW-1:0]  w_rad;
    logic [RootW-1:0] w_root;
    logic [LenW-1:0]  w_len;
    logic [QuoW-1:0]  w_qx, w_qy;
    logic [NormW-1:0] w_nx, w_ny;

    logic             r_o_vld;
    t_side            r_o_side;
    logic [LenW-1:0]  r_o_len;
    logic [NormW-1:0] r_o_nx, r_o_ny;
    logic [AreaW-1:0] r_o_area;
    logic             r_o_zero, r_o_last;

    assign w_adv = !r_o_vld || o_face.ready;

    qcfm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cell  (i_cell),
        .o_valid (w_f_vld),
        .o_tag   (w_f_tag),
        .o_rad   (w_rad)
    );

    qcfm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_f_vld),
        .i_tag   (w_f_tag),
        .i_rad   (w_rad),
        .o_valid (w_s_vld),
        .o_tag   (w_s_tag),
        .o_root  (w_root)
    );

    qcfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_s_vld),
        .i_tag   (w_s_tag),
        .i_root  (w_root),
        .o_valid (w_d_vld),
        .o_tag   (w_d_tag),
        .o_len   (w_len),
        .o_qx    (w_qx),
        .o_qy    (w_qy)
    );

    assign w_nx = w_d_tag.nx_neg ? -NormW'(w_qx) : NormW'(w_qx);
    assign w_ny = w_d_tag.ny_neg ? -NormW'(w_qy) : NormW'(w_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld  <= w_d_vld;
            r_o_side <= w_d_tag.side;
            r_o_area <= w_d_tag.area;
            r_o_last <= w_d_tag.last;
            r_o_zero <= w_d_tag.zero;
            // zero-length face: divider result is meaningless
            r_o_len  <= w_d_tag.zero ? '0 : w_len;
            r_o_nx   <= w_d_tag.zero ? '0 : w_nx;
            r_o_ny   <= w_d_tag.zero ? '0 : w_ny;
        end
    end

    assign o_face.valid       = r_o_vld;
    assign o_face.face_side   = r_o_side;
    assign o_face.face_length = r_o_len;
    assign o_face.normal_x    = r_o_nx;
    assign o_face.normal_y    = r_o_ny;
    assign o_face.cell_area   = r_o_area;
    assign o_face.zero_face   = r_o_zero;
    assign o_face.last_face   = r_o_last;

endmodule

>>> bench/qcfm_tb_if.sv
// ----------------------------------------------------------------------------
// qcfm_tb_if
// testbench side helpers: the expected face record beside the design interfaces
// ----------------------------------------------------------------------------
// the design interfaces qcfm_cell_if and qcfm_face_if are used directly
package qcfm_tb_pkg;
    import qcfm_pkg::*;

    typedef struct {
        t_side        side;
        logic [31:0]  length;
        logic [15:0]  nx;
        logic [15:0]  ny;
        logic [62:0]  area;
        logic         zero;
        logic         last;
    } t_face_exp;
endpackage

>>> bench/quad_cell_face_metrics_tb.sv
// ----------------------------------------------------------------------------
// quad_cell_face_metrics_tb
// checks face lengths, unit normals and cell area of the quad cell block
// ----------------------------------------------------------------------------
// Directed cells and random bursts with gaps; each cell beat is turned
// into its four face beats by an exact integer model and compared in order.
// ----------------------------------------------------------------------------
module quad_cell_face_metrics_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qcfm_pkg::*;
    import qcfm_tb_pkg::*;

    localparam int LATENCY = 67;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors = 0;
    bit   hold_off = 1'b0;
    event hold_start;
    int   stall_pct = 30;
    int   gap_max = 6;

    qcfm_cell_if cell_ch ();
    qcfm_face_if face_ch ();

    t_face_exp face_queue[$];

    quad_cell_face_metrics dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_ch.sink),
        .o_face  (face_ch.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // floor(sqrt(s)) for s below 2^96
    function automatic logic [47:0] isqrt(logic [95:0] s);
        logic [47:0]  r;
        logic [47:0]  c;
        r = '0;
        for (int b = 47; b >= 0; b--) begin
            c = r | (48'd1 << b);
            if ({48'd0, c} * {48'd0, c} <= s) r = c;
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_comp(logic signed [33:0] num, logic [47:0] r);
        logic [33:0] m;
        logic [95:0] q;
        m = num < 0 ? -num : num;
        q = ({62'd0, m} << 28) + {48'd0, r >> 1};
        q = q / {48'd0, r};
        if (q > 96'd16384) q = 96'd16384;
        return num < 0 ? -q[15:0] : q[15:0];
    endfunction

    function automatic t_face_exp face_metrics(t_side sd, logic signed [31:0] px,
            logic signed [31:0] py, logic signed [31:0] qx, logic signed [31:0] qy,
            logic [62:0] area);
        t_face_exp e;
        logic signed [33:0] nxn;
        logic signed [33:0] nyn;
        logic [95:0] s;
        logic [47:0] r;
        nxn = py - qy;
        nyn = qx - px;
        s = 96'(nxn) * 96'(nxn) + 96'(nyn) * 96'(nyn);
        e.side = sd; e.area = area; e.last = (sd == SIDE_SOUTH);
        if (s == 0) begin
            e.length = '0; e.nx = '0; e.ny = '0; e.zero = 1'b1;
        end else begin
            r = isqrt(s << 28);
            e.length = (r >> 14) > 48'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(r >> 14);
            e.nx = unit_comp(nxn, r);
            e.ny = unit_comp(nyn, r);
            e.zero = 1'b0;
        end
        return e;
    endfunction

    task automatic predict_cell(logic signed [31:0] c[8]);
        logic signed [33:0] dx1, dy1, dx2, dy2;
        logic signed [69:0] cr;
        logic [69:0] acr;
        logic [62:0] area;
        dx1 = c[6] - c[0]; dy1 = c[7] - c[1];
        dx2 = c[4] - c[2]; dy2 = c[5] - c[3];
        cr = 70'(dx1) * 70'(dy2) - 70'(dx2) * 70'(dy1);
        acr = cr < 0 ? -cr : cr;
        acr = acr >> 1;
        area = acr > 70'h7FFF_FFFF_FFFF_FFFF ? AREA_MAX : acr[62:0];
        face_queue.push_back(face_metrics(SIDE_EAST, c[6], c[7], c[2], c[3], area));
        face_queue.push_back(face_metrics(SIDE_WEST, c[0], c[1], c[4], c[5], area));
        face_queue.push_back(face_metrics(SIDE_NORTH, c[4], c[5], c[6], c[7], area));
        face_queue.push_back(face_metrics(SIDE_SOUTH, c[2], c[3], c[0], c[1], area));
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // receiver: random stall pattern plus long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            face_ch.ready <= 1'b0;
        end else if (hold_off) begin
            face_ch.ready <= 1'b0;
        end else begin
            face_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // long hold-off, counted in cycles once requested
    always begin
        @(hold_start);
        hold_off <= 1'b1;
        repeat (400) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_face_exp e;
        if (i_rst_n && face_ch.valid && face_ch.ready) begin
            if (face_queue.size() == 0) begin
                $display("face beat with nothing expected at %0t", $realtime);
                errors++;
            end else begin
                e = face_queue.pop_front();
                if (face_ch.face_side != e.side) report("face_side", face_ch.face_side, e.side);
                if (face_ch.face_length != e.length)
                    report("face_length", face_ch.face_length, e.length);
                if (face_ch.normal_x != e.nx) report("normal_x", face_ch.normal_x, e.nx);
                if (face_ch.normal_y != e.ny) report("normal_y", face_ch.normal_y, e.ny);
                if (face_ch.cell_area != e.area) report("cell_area", face_ch.cell_area, e.area);
                if (face_ch.zero_face != e.zero) report("zero_face", face_ch.zero_face, e.zero);
                if (face_ch.last_face != e.last) report("last_face", face_ch.last_face, e.last);
            end
        end
    end

    task automatic send_cell(logic signed [31:0] c[8]);
        cell_ch.valid <= 1'b1;
        cell_ch.bottom_left_x <= c[0];  cell_ch.bottom_left_y <= c[1];
        cell_ch.bottom_right_x <= c[2]; cell_ch.bottom_right_y <= c[3];
        cell_ch.top_left_x <= c[4];     cell_ch.top_left_y <= c[5];
        cell_ch.top_right_x <= c[6];    cell_ch.top_right_y <= c[7];
        do @(posedge i_clk); while (!cell_ch.ready);
        predict_cell(c);
        @(negedge i_clk);
    endtask

    task automatic idle_cell(int n);
        cell_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        cell_ch.valid <= 1'b0;
        while (face_queue.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord(int shape);
        case (shape)
            0: return $urandom();
            1: return $signed($urandom_range(2000)) - 1000;
            2: return $signed(($urandom_range(65535) << 4)) - 32'sd524288;
            default: return $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(3)
                                              : 32'sh8000_0000 + $urandom_range(3);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] c[8];
        int v[5] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 32'sh0001_0000};
        // unit square
        c = '{0, 0, 32'sh10000, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000};
        send_cell(c);
        // every corner at one point: all faces zero length
        c = '{5, 5, 5, 5, 5, 5, 5, 5};
        send_cell(c);
        // two collapsed faces
        c = '{0, 0, 32'sh20000, 0, 0, 0, 32'sh20000, 0};
        send_cell(c);
        // extreme corners: maximal lengths and saturated area
        c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_cell(c);
        c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        send_cell(c);
        // crossed cell
        c = '{0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000, 0};
        send_cell(c);
        // single lsb faces, diagonal normals
        c = '{0, 0, 1, 0, 0, 1, 1, 1};
        send_cell(c);
        c = '{0, 0, 1, -1, -1, 1, 0, 0};
        send_cell(c);
        for (int k = 0; k < 12; k++) begin
            for (int j = 0; j < 8; j++) c[j] = v[(k + j * (k % 3 + 1)) % 5];
            send_cell(c);
        end
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic signed [31:0] c[8];
        int shape;
        int burst;
        int gap;
        int sent = 0;
        while (sent < count) begin
            burst = $urandom_range(12, 1);
            for (int b = 0; b < burst && sent < count; b++) begin
                shape = $urandom_range(3);
                for (int j = 0; j < 8; j++) begin
                    c[j] = rand_coord($urandom_range(9) == 0 ? 3 : shape);
                end
                if ($urandom_range(19) == 0) c[$urandom_range(3) * 2] = c[6];
                send_cell(c);
                sent++;
            end
            if ($urandom_range(3) != 0) begin
                gap = $urandom_range(gap_max);
                if (gap > 0) idle_cell(gap);
            end
        end
    endtask

    task automatic test_backpressure();
        // long receiver hold-off while cells keep coming: input must stall
        -> hold_start;
        test_random(40);
        wait_drained();
    endtask

    task automatic test_no_stall();
        stall_pct = 0;
        gap_max = 0;
        test_random(60);
        wait_drained();
        stall_pct = 30;
        gap_max = 6;
    endtask

    initial begin
        cell_ch.valid = 1'b0;
        cell_ch.bottom_left_x = '0; cell_ch.bottom_left_y = '0;
        cell_ch.bottom_right_x = '0; cell_ch.bottom_right_y = '0;
        cell_ch.top_left_x = '0; cell_ch.top_left_y = '0;
        cell_ch.top_right_x = '0; cell_ch.top_right_y = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(150);
        wait_drained();
        test_backpressure();
        test_no_stall();
        stall_pct = 70;
        test_random(90);
        wait_drained();
        repeat (LATENCY + 20) @(negedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
